>>> hw/rtl/wgma_pkg.sv
// wgma_pkg: shared types and constants of the weighted gram matrix accumulator
// command and status records between controller and datapath
// no dependencies
package wgma_pkg;

    // width of a row or column index, fixed by the entry_row and entry_col fields
    localparam int IDX_W = 3;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MUL,
        OP_ABS,
        OP_MLO,
        OP_MHI,
        OP_SUM,
        OP_SAT,
        OP_NEG,
        OP_ADD,
        OP_EREAD,
        OP_ELOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

>>> hw/rtl/weighted_gram_matrix_accumulator.sv
// weighted_gram_matrix_accumulator: accumulates sum of w * b[j] * a[l] over rows
// element at column c: c+1 terms, each via mul, abs, mlo, mhi, sum, sat, neg and add
// emit: K*K entries, each an accumulator read, then an output load once the output is free
// reset: synchronous active-low; accumulators read zero through per-entry valid flags, no
// clearing pass; column count resets to 8, position and overflow to zero
// depends on wgma_pkg, wgma_ctrl, wgma_datapath, wgma_ram
module weighted_gram_matrix_accumulator #(
    parameter int MAX_COLS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: column count K
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    // element request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_a_value,
    input  logic signed [31:0] i_b_value,
    input  logic [31:0]        i_weight,
    input  logic               i_last_row,
    // matrix entry request channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_entry_value,
    output logic [2:0]         o_entry_row,
    output logic [2:0]         o_entry_col,
    output logic               o_overflow,
    output logic               o_last_entry
);

    // controller walks terms j = 0..col per element, then the K by K emit after a final row
    wgma_pkg::t_dp_cmd    cmd;
    wgma_pkg::t_dp_status status;

    wgma_ctrl #(
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_last_row (i_last_row),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: b row buffer, multiplier chain, accumulator ram, output register
    wgma_datapath #(
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_a_value     (i_a_value),
        .i_b_value     (i_b_value),
        .i_weight      (i_weight),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_entry_value (o_entry_value),
        .o_entry_row   (o_entry_row),
        .o_entry_col   (o_entry_col),
        .o_overflow    (o_overflow),
        .o_last_entry  (o_last_entry)
    );

    // an accepted element always starts a multi-cycle term pass
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after an element request");

    // once the final entry is taken, only the first entry of a new matrix can follow at once
    a_new_matrix_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_entry && !i_out_stall) |=>
            (!o_out_valid || (o_entry_row == 3'd0 && o_entry_col == 3'd0)))
        else $error("entry after the final entry is not the first of a new matrix");

    // final entry sits on the diagonal (K-1, K-1)
    a_last_diagonal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_entry) |-> (o_entry_row == o_entry_col))
        else $error("final entry off the diagonal");

    // no element is taken while an emitted entry other than the final one waits
    a_no_accept_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_entry) |-> o_in_stall)
        else $error("element request accepted during matrix emit");

endmodule

>>> hw/rtl/wgma_ram.sv
// wgma_ram: generic single write port, single read port ram with registered read
// no dependencies
module wgma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 36
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/wgma_ctrl.sv
// wgma_ctrl: sequencer for term accumulation and matrix emission
// depends on wgma_pkg
module wgma_ctrl #(
    parameter int MAX_COLS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_last_row,
    output logic                 o_in_stall,
    input  wgma_pkg::t_dp_status i_status,
    output wgma_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ABS,
        S_MLO,
        S_MHI,
        S_SUM,
        S_SAT,
        S_NEG,
        S_ADD,
        S_EREAD,
        S_ELOAD
    } t_state;

    localparam logic [3:0] MAX_K = 4'(MAX_COLS);

    t_state r_state, n_state;
    logic [3:0] r_cols, n_cols;
    logic [wgma_pkg::IDX_W-1:0] r_col_pos, n_col_pos;
    logic [wgma_pkg::IDX_W-1:0] r_col, n_col;
    logic [wgma_pkg::IDX_W-1:0] r_j, n_j;
    logic [wgma_pkg::IDX_W-1:0] r_er, n_er;
    logic [wgma_pkg::IDX_W-1:0] r_ec, n_ec;
    logic r_final, n_final;

    logic [3:0] k;
    logic [wgma_pkg::IDX_W-1:0] col_eff;
    logic last_c;

    always_comb begin
        // clamp the column count into 1..MAX_COLS
        if (r_cols == 4'd0) begin
            k = 4'd1;
        end else if (r_cols > MAX_K) begin
            k = MAX_K;
        end else begin
            k = r_cols;
        end
        col_eff = ({1'b0, r_col_pos} >= k) ? '0 : r_col_pos;
        last_c  = ({1'b0, r_er} == k - 4'd1) && ({1'b0, r_ec} == k - 4'd1);

        n_state   = r_state;
        n_cols    = r_cols;
        n_col_pos = r_col_pos;
        n_col     = r_col;
        n_j       = r_j;
        n_er      = r_er;
        n_ec      = r_ec;
        n_final   = r_final;

        o_cmd      = '0;
        o_cmd.op   = wgma_pkg::OP_IDLE;
        o_cmd.row  = r_j;
        o_cmd.col  = r_col;
        o_cmd.last = 1'b0;

        if (i_cfg_we) begin
            n_cols    = i_cfg_data;
            n_col_pos = '0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_cmd.col = col_eff;
                if (i_in_valid) begin
                    o_cmd.op = wgma_pkg::OP_LOAD;
                    n_col    = col_eff;
                    n_j      = '0;
                    n_final  = i_last_row;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = wgma_pkg::OP_MUL;
                n_state  = S_ABS;
            end
            S_ABS: begin
                o_cmd.op = wgma_pkg::OP_ABS;
                n_state  = S_MLO;
            end
            S_MLO: begin
                o_cmd.op = wgma_pkg::OP_MLO;
                n_state  = S_MHI;
            end
            S_MHI: begin
                o_cmd.op = wgma_pkg::OP_MHI;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = wgma_pkg::OP_SUM;
                n_state  = S_SAT;
            end
            S_SAT: begin
                o_cmd.op = wgma_pkg::OP_SAT;
                n_state  = S_NEG;
            end
            S_NEG: begin
                o_cmd.op = wgma_pkg::OP_NEG;
                n_state  = S_ADD;
            end
            S_ADD: begin
                o_cmd.op = wgma_pkg::OP_ADD;
                if (r_j == r_col) begin
                    // all terms of this element done
                    if ({1'b0, r_col} + 4'd1 < k) begin
                        n_col_pos = r_col + 3'd1;
                        n_state   = S_IDLE;
                    end else begin
                        n_col_pos = '0;
                        if (r_final) begin
                            n_er    = '0;
                            n_ec    = '0;
                            n_state = S_EREAD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_j     = r_j + 3'd1;
                    n_state = S_MUL;
                end
            end
            S_EREAD: begin
                o_cmd.op  = wgma_pkg::OP_EREAD;
                o_cmd.row = r_er;
                o_cmd.col = r_ec;
                n_state   = S_ELOAD;
            end
            S_ELOAD: begin
                o_cmd.row  = r_er;
                o_cmd.col  = r_ec;
                o_cmd.last = last_c;
                if (i_status.out_free) begin
                    o_cmd.op = wgma_pkg::OP_ELOAD;
                    if (last_c) begin
                        n_state = S_IDLE;
                    end else begin
                        if ({1'b0, r_ec} == k - 4'd1) begin
                            n_ec = '0;
                            n_er = r_er + 3'd1;
                        end else begin
                            n_ec = r_ec + 3'd1;
                        end
                        n_state = S_EREAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cols    <= 4'd8;
            r_col_pos <= '0;
            r_col     <= '0;
            r_j       <= '0;
            r_er      <= '0;
            r_ec      <= '0;
            r_final   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cols    <= n_cols;
            r_col_pos <= n_col_pos;
            r_col     <= n_col;
            r_j       <= n_j;
            r_er      <= n_er;
            r_ec      <= n_ec;
            r_final   <= n_final;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> hw/rtl/wgma_datapath.sv
// wgma_datapath: term multiplier chain, saturating accumulate, output register
// depends on wgma_pkg and wgma_ram
module wgma_datapath #(
    parameter int MAX_COLS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wgma_pkg::t_dp_cmd    i_cmd,
    output wgma_pkg::t_dp_status o_status,
    input  logic signed [31:0]   i_a_value,
    input  logic signed [31:0]   i_b_value,
    input  logic [31:0]          i_weight,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [63:0]   o_entry_value,
    output logic [2:0]           o_entry_row,
    output logic [2:0]           o_entry_col,
    output logic                 o_overflow,
    output logic                 o_last_entry
);

    localparam int TRI_COUNT = MAX_COLS * (MAX_COLS + 1) / 2;
    localparam int TRI_W     = (TRI_COUNT > 1) ? $clog2(TRI_COUNT) : 1;
    localparam int BUF_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

    // packed upper triangle position of (j, l), j <= l
    function automatic logic [TRI_W-1:0] tri_idx(
        input logic [wgma_pkg::IDX_W-1:0] j,
        input logic [wgma_pkg::IDX_W-1:0] l
    );
        logic [7:0] jj;
        logic [7:0] ll;
        logic [7:0] t;
        jj = {5'b0, j};
        ll = {5'b0, l};
        t  = jj * 8'(MAX_COLS) - ((jj * (jj - {7'b0, (jj != 8'd0)})) >> 1) + (ll - jj);
        return t[TRI_W-1:0];
    endfunction

    logic signed [31:0] r_a;
    logic [31:0]        r_w;
    logic signed [31:0] r_bbuf [MAX_COLS];
    logic signed [63:0] r_prod;
    logic               r_neg;
    logic [63:0]        r_mag;
    logic [63:0]        r_lo;
    logic [63:0]        r_hi;
    logic [95:0]        r_total;
    logic [63:0]        r_qclip;
    logic               r_tsat;
    logic signed [63:0] r_term;
    logic [TRI_COUNT-1:0] r_valid;
    logic               r_rd_valid;
    logic               r_sticky;

    logic               r_out_valid;
    logic signed [63:0] r_entry_value;
    logic [2:0]         r_entry_row;
    logic [2:0]         r_entry_col;
    logic               r_overflow;
    logic               r_last_entry;

    logic [wgma_pkg::IDX_W-1:0] lo_idx, hi_idx;
    logic [TRI_W-1:0]   addr;
    logic               ram_re, ram_we;
    logic [63:0]        rdata;
    logic signed [63:0] acc;
    logic signed [64:0] sum_w;
    logic signed [63:0] sum_sat;
    logic               sum_ovf;
    logic signed [63:0] prod_c;
    logic [63:0]        lo_c, hi_c;
    logic [79:0]        q_c;
    logic [63:0]        limit_c;
    logic               over_c;
    logic               out_free;

    // emission reads (r, c) as (min, max)
    assign lo_idx = (i_cmd.row <= i_cmd.col) ? i_cmd.row : i_cmd.col;
    assign hi_idx = (i_cmd.row <= i_cmd.col) ? i_cmd.col : i_cmd.row;
    assign addr   = tri_idx(lo_idx, hi_idx);

    assign ram_re = (i_cmd.op == wgma_pkg::OP_MUL) || (i_cmd.op == wgma_pkg::OP_EREAD);
    assign ram_we = (i_cmd.op == wgma_pkg::OP_ADD);

    wgma_ram #(
        .WIDTH (64),
        .DEPTH (TRI_COUNT)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (sum_sat),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    assign prod_c  = r_a * r_bbuf[i_cmd.row[BUF_W-1:0]];
    assign lo_c    = r_mag[31:0] * r_w;
    assign hi_c    = r_mag[63:32] * r_w;
    assign q_c     = r_total[95:16];
    assign limit_c = r_neg ? NEG_LIMIT : POS_LIMIT;
    assign over_c  = (q_c[79:64] != 16'd0) || (q_c[63:0] > limit_c);

    // entries never written since the last clear read as zero
    assign acc     = r_rd_valid ? $signed(rdata) : 64'sd0;
    assign sum_w   = {acc[63], acc} + {r_term[63], r_term};
    assign sum_ovf = (sum_w[64] != sum_w[63]);
    assign sum_sat = sum_ovf ? (sum_w[64] ? $signed(NEG_LIMIT) : $signed(POS_LIMIT))
                             : sum_w[63:0];

    assign out_free          = !r_out_valid || !i_out_stall;
    assign o_status.out_free = out_free;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            wgma_pkg::OP_LOAD: begin
                r_a <= i_a_value;
                r_w <= i_weight;
                r_bbuf[i_cmd.col[BUF_W-1:0]] <= i_b_value;
            end
            wgma_pkg::OP_MUL: begin
                r_prod <= prod_c;
            end
            wgma_pkg::OP_ABS: begin
                r_neg <= r_prod[63];
                r_mag <= r_prod[63] ? (~r_prod + 64'd1) : r_prod;
            end
            wgma_pkg::OP_MLO: begin
                r_lo <= lo_c;
            end
            wgma_pkg::OP_MHI: begin
                r_hi <= hi_c;
            end
            wgma_pkg::OP_SUM: begin
                // rounding constant for the shift by 16
                r_total <= {32'd0, r_lo} + {r_hi, 32'd0} + 96'h8000;
            end
            wgma_pkg::OP_SAT: begin
                r_qclip <= over_c ? limit_c : q_c[63:0];
                r_tsat  <= over_c;
            end
            wgma_pkg::OP_NEG: begin
                r_term <= r_neg ? -$signed(r_qclip) : $signed(r_qclip);
            end
            default: begin
            end
        endcase
        if (ram_re) begin
            r_rd_valid <= r_valid[addr];
        end
        if (i_cmd.op == wgma_pkg::OP_ELOAD) begin
            r_entry_value <= acc;
            r_entry_row   <= i_cmd.row;
            r_entry_col   <= i_cmd.col;
            r_overflow    <= r_sticky;
            r_last_entry  <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                r_valid[addr] <= 1'b1;
                if (r_tsat || sum_ovf) begin
                    r_sticky <= 1'b1;
                end
            end
            if (i_cmd.op == wgma_pkg::OP_ELOAD) begin
                r_out_valid <= 1'b1;
                if (i_cmd.last) begin
                    r_valid  <= '0;
                    r_sticky <= 1'b0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_value = r_entry_value;
    assign o_entry_row   = r_entry_row;
    assign o_entry_col   = r_entry_col;
    assign o_overflow    = r_overflow;
    assign o_last_entry  = r_last_entry;

endmodule

>>> sim/tb_weighted_gram_matrix_accumulator.sv
// testbench for weighted_gram_matrix_accumulator: drives element requests and checks
// every emitted matrix entry against a cycle-free predictor of the gram accumulation
// depends on wgma_pkg and the weighted_gram_matrix_accumulator rtl
`timescale 1ns / 100ps

module tb_weighted_gram_matrix_accumulator;

    localparam int MAX_COLS  = 8;
    localparam int TRI_SLOTS = MAX_COLS * (MAX_COLS + 1) / 2;
    localparam int IDX_W     = wgma_pkg::IDX_W;
    // margin after a drain, past the busy time of an element at the last column and the output stage
    localparam int SETTLE    = 200;
    localparam int LIMIT     = 600000;
    localparam int PHASE_ITEMS = 25;
    localparam int HOLD_LEN  = 600;

    localparam logic [31:0] Q16_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q16_HALF = 32'h0000_8000;
    localparam logic [31:0] S32_MIN  = 32'h8000_0000;
    localparam logic [31:0] S32_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] U32_MAX  = 32'hFFFF_FFFF;
    localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]        w;
        logic               last;
    } elem_t;

    typedef struct {
        logic signed [63:0] value;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic               ovf;
        logic               last;
    } entry_t;

    // dut ports, all inputs driven to known values from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [3:0]         i_cfg_data = 4'd0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_a_value = '0;
    logic signed [31:0] i_b_value = '0;
    logic [31:0]        i_weight = '0;
    logic               i_last_row = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [63:0] o_entry_value;
    logic [2:0]         o_entry_row;
    logic [2:0]         o_entry_col;
    logic               o_overflow;
    logic               o_last_entry;

    weighted_gram_matrix_accumulator #(.MAX_COLS(MAX_COLS)) dut (.*);

    // predictor state: column count, upper triangle, current b row, position, sticky flag
    logic [3:0]         cols_q;
    logic signed [63:0] upper_acc[TRI_SLOTS];
    logic signed [31:0] b_row[MAX_COLS];
    int                 col_pos;
    logic               sticky_ovf;

    elem_t  pending_q[$];     // elements waiting to be offered
    entry_t entries_due[$];   // matrix entries predicted but not yet seen
    elem_t  cur_elem;
    logic   in_busy = 1'b0;   // cur_elem is on the bus and not yet taken
    int     tx_gap = 0;
    int     rx_wait = 0;
    int     hold_cycles = 0;
    logic   tx_idle = 1'b0;
    logic   rx_idle = 1'b0;
    int     err_count = 0;
    int     cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // packed upper triangle, row j holds columns j..MAX_COLS-1
    function automatic int tri_slot(input int j, input int l);
        return (j == 0) ? l : j * MAX_COLS - (j * (j - 1)) / 2 + (l - j);
    endfunction

    // one accepted element: add w*b[j]*a[col] into every (j, col), emit on a completed final row
    task automatic gram_accept(input elem_t e);
        int                 k;
        int                 col;
        int                 slot;
        longint             pa;
        longint             pb;
        logic signed [63:0] prod;
        logic [63:0]        mag;
        logic [127:0]       wide;
        logic [63:0]        lim;
        logic signed [63:0] term;
        logic [64:0]        sum;
        logic               neg;
        logic               sat;
        entry_t             ent;
        k = (cols_q == 4'd0) ? 1 : ((cols_q > MAX_COLS) ? MAX_COLS : int'(cols_q));
        col = (col_pos >= k) ? 0 : col_pos;
        b_row[col] = e.b;
        for (int j = 0; j <= col; j++) begin
            sat  = 1'b0;
            pa   = e.a;
            pb   = b_row[j];
            prod = pa * pb;
            neg  = prod[63];
            mag  = neg ? -prod : prod;
            // magnitude times weight, round half away from zero, back to q32.32
            wide = {64'd0, mag} * {96'd0, e.w};
            wide = wide + 128'h8000;
            wide = wide >> 16;
            lim  = neg ? S64_MIN : S64_MAX;
            if (wide > {64'd0, lim}) begin
                wide = {64'd0, lim};
                sat  = 1'b1;
            end
            term = neg ? -wide[63:0] : wide[63:0];
            slot = tri_slot(j, col);
            sum  = {upper_acc[slot][63], upper_acc[slot]} + {term[63], term};
            case (sum[64:63])
                2'b01: begin
                    upper_acc[slot] = S64_MAX;
                    sat = 1'b1;
                end
                2'b10: begin
                    upper_acc[slot] = S64_MIN;
                    sat = 1'b1;
                end
                default: upper_acc[slot] = sum[63:0];
            endcase
            if (sat) sticky_ovf = 1'b1;
        end
        col++;
        if (col < k) begin
            col_pos = col;
        end else begin
            col_pos = 0;
            if (e.last) begin
                // full matrix, lower triangle mirrored
                for (int r = 0; r < k; r++) begin
                    for (int c = 0; c < k; c++) begin
                        ent.value = upper_acc[(r <= c) ? tri_slot(r, c) : tri_slot(c, r)];
                        ent.row   = IDX_W'(r);
                        ent.col   = IDX_W'(c);
                        ent.ovf   = sticky_ovf;
                        ent.last  = (r == k - 1) && (c == k - 1);
                        entries_due.push_back(ent);
                    end
                end
                for (int i = 0; i < TRI_SLOTS; i++) upper_acc[i] = '0;
                sticky_ovf = 1'b0;
            end
        end
    endtask

    // sender: new payload at the falling edge once the previous request is gone
    always @(negedge i_clk) begin
        if (!i_rst_n || in_busy) begin
            // hold the stalled payload as it is
        end else if (tx_gap > 0) begin
            tx_gap = tx_gap - 1;
            i_in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
            cur_elem = pending_q.pop_front();
            in_busy  = 1'b1;
            i_a_value  <= cur_elem.a;
            i_b_value  <= cur_elem.b;
            i_weight   <= cur_elem.w;
            i_last_row <= cur_elem.last;
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // element request taken at the rising edge: predict, draw the next gap
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            gram_accept(cur_elem);
            in_busy = 1'b0;
            tx_gap  = tx_idle ? $urandom_range(0, 10) : 0;
        end
    end

    // receiver: compare each taken entry with the oldest prediction
    always @(posedge i_clk) begin
        entry_t exp_ent;
        if (i_rst_n && o_out_valid) begin
            if (!i_out_stall) begin
                if (entries_due.size() == 0) begin
                    $error("unexpected entry row %0d col %0d value %0d",
                           o_entry_row, o_entry_col, o_entry_value);
                    err_count++;
                end else begin
                    exp_ent = entries_due.pop_front();
                    if (o_entry_value !== exp_ent.value) begin
                        $error("entry_value: expected %0d, got %0d", exp_ent.value, o_entry_value);
                        err_count++;
                    end
                    if (o_entry_row !== exp_ent.row) begin
                        $error("entry_row: expected %0d, got %0d", exp_ent.row, o_entry_row);
                        err_count++;
                    end
                    if (o_entry_col !== exp_ent.col) begin
                        $error("entry_col: expected %0d, got %0d", exp_ent.col, o_entry_col);
                        err_count++;
                    end
                    if (o_overflow !== exp_ent.ovf) begin
                        $error("overflow: expected %0d, got %0d", exp_ent.ovf, o_overflow);
                        err_count++;
                    end
                    if (o_last_entry !== exp_ent.last) begin
                        $error("last_entry: expected %0d, got %0d", exp_ent.last, o_last_entry);
                        err_count++;
                    end
                end
                rx_wait = rx_idle ? $urandom_range(0, 10) : 0;
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
            end
        end
    end

    // long receiver hold-off, counted here so the sender keeps running meanwhile
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles = hold_cycles - 1;
    end

    always @(negedge i_clk) begin
        i_out_stall <= (hold_cycles > 0) || (rx_wait > 0);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("tb_weighted_gram_matrix_accumulator: done, errors");
            $finish;
        end
    end

    function automatic elem_t mk(input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] w, input logic last);
        elem_t e;
        e.a = a;
        e.b = b;
        e.w = w;
        e.last = last;
        return e;
    endfunction

    // mostly small q16.16 values so sums stay in range, some full range and extremes
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 5))
                    0: return S32_MIN;
                    1: return S32_MAX;
                    2: return 32'd0;
                    3: return U32_MAX;
                    4: return Q16_ONE;
                    default: return 32'hFFFF_0000;
                endcase
            end
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return Q16_ONE;
            4, 5, 6:    return $urandom_range(0, 32'h0004_0000);
            7:          return $urandom;
            8:          return $urandom_range(0, 1) ? U32_MAX : 32'd0;
            default:    return $urandom_range(0, 32'h0000_FFFF);
        endcase
    endfunction

    // one data set of whole rows; stray mid-row final flags in the last row, in all rows if noisy
    task automatic push_set(input int k, input int rows, input logic noisy);
        logic [31:0] w;
        logic        last;
        for (int r = 0; r < rows; r++) begin
            w = pick_weight();
            for (int c = 0; c < k; c++) begin
                if (r == rows - 1)
                    last = (c == k - 1) ? !(noisy && $urandom_range(0, 15) == 0)
                                        : 1'($urandom_range(0, 1));
                else
                    last = (c < k - 1) && noisy && ($urandom_range(0, 3) == 0);
                pending_q.push_back(mk(pick_q16(), pick_q16(), w, last));
            end
        end
    endtask

    task automatic write_cols(input logic [3:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        cols_q  = v;
        col_pos = 0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sender pauses until every predicted entry is out and the block has gone quiet
    task automatic drain();
        while (pending_q.size() > 0 || in_busy || entries_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] ext_tab[MAX_COLS];
        logic [3:0]  cfg_list[12];
        int          k;
        int          n;
        int          rows;

        ext_tab  = '{S32_MIN, S32_MAX, 32'd0, U32_MAX, Q16_ONE, 32'hFFFF_0000,
                     32'd1, 32'hC000_0000};
        cfg_list = '{4'd0, 4'd15, 4'd2, 4'd8, 4'd3, 4'd9, 4'd5, 4'd1, 4'd4, 4'd7,
                     4'd6, 4'd12};

        cols_q     = 4'd8;
        col_pos    = 0;
        sticky_ovf = 1'b0;
        for (int i = 0; i < TRI_SLOTS; i++) upper_acc[i] = '0;
        for (int i = 0; i < MAX_COLS; i++) b_row[i] = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset column count of 8: one final row of extreme values
        for (int c = 0; c < MAX_COLS; c++)
            pending_q.push_back(mk(ext_tab[c], ext_tab[MAX_COLS - 1 - c], Q16_ONE,
                                   c == MAX_COLS - 1));
        drain();

        write_cols(4'd2);
        // term saturation, positive and negative, at full weight
        pending_q.push_back(mk(S32_MAX, S32_MAX, U32_MAX, 1'b0));
        pending_q.push_back(mk(S32_MIN, S32_MIN, U32_MAX, 1'b1));
        // half-lsb ties round away from zero; final flag on column 0 is ignored
        pending_q.push_back(mk(32'd1, 32'd1, Q16_HALF, 1'b1));
        pending_q.push_back(mk(U32_MAX, 32'd1, Q16_HALF, 1'b0));
        pending_q.push_back(mk(32'd0, 32'd0, 32'd0, 1'b1));
        pending_q.push_back(mk(Q16_ONE, 32'hFFFF_0000, Q16_ONE, 1'b1));
        // near-limit terms that only saturate once summed, both signs
        for (int r = 0; r < 3; r++) begin
            pending_q.push_back(mk(S32_MAX, S32_MAX, 32'h0002_0000, 1'b0));
            pending_q.push_back(mk(S32_MIN, S32_MAX, 32'h0002_0000, r == 2));
        end
        // half a row, dropped by the next register write
        pending_q.push_back(mk(32'h0003_0000, 32'h0005_0000, Q16_ONE, 1'b0));
        drain();

        // random phases, one column count each, zero and above-range values included
        for (int p = 0; p < 12; p++) begin
            write_cols(cfg_list[p]);
            k = (cfg_list[p] == 4'd0) ? 1 : ((cfg_list[p] > MAX_COLS) ? MAX_COLS
                                                                       : int'(cfg_list[p]));
            {tx_idle, rx_idle} = (p == 2) ? 2'b00 : 2'(p % 4);
            if (p == 2) hold_cycles = HOLD_LEN;   // back-pressure fills the block
            n = 0;
            while (n < PHASE_ITEMS) begin
                rows = $urandom_range(1, (k <= 4) ? 4 : 2);
                push_set(k, rows, $urandom_range(0, 3) == 0);
                n = n + k * rows;
                if (n >= PHASE_ITEMS / 2 && n - k * rows < PHASE_ITEMS / 2) drain();
            end
            // broken sequence: a partial row right before the next register write
            if (p < 11 && k > 1 && $urandom_range(0, 1)) begin
                for (int c = 0; c < $urandom_range(1, k - 1); c++)
                    pending_q.push_back(mk(pick_q16(), pick_q16(), pick_weight(),
                                           1'($urandom_range(0, 1))));
            end
            drain();
        end

        if (err_count == 0) begin
            $display("tb_weighted_gram_matrix_accumulator: done, clean");
        end else begin
            $display("tb_weighted_gram_matrix_accumulator: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/wgma_pkg.sv
hw/rtl/wgma_ram.sv
hw/rtl/wgma_ctrl.sv
hw/rtl/wgma_datapath.sv
hw/rtl/weighted_gram_matrix_accumulator.sv
sim/tb_weighted_gram_matrix_accumulator.sv
